/* rtl/symmetry_vector_tensor_transform_unit_assert.svh */
// assertion macros for the symmetry transform unit
`ifndef SYMMETRY_VECTOR_TENSOR_TRANSFORM_UNIT_ASSERT_SVH
`define SYMMETRY_VECTOR_TENSOR_TRANSFORM_UNIT_ASSERT_SVH

// cons must hold in the same cycle as ante
`define SVT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define SVT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/svt_pkg.sv */
package svt_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_COEF_WIDTH = 16;

    localparam int NUM_COMP    = 6;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_ZERO = 3'd0,
        REG_ROW_ONE  = 3'd1,
        REG_ROW_TWO  = 3'd2,
        REG_SHIFT_X  = 3'd3,
        REG_SHIFT_Y  = 3'd4,
        REG_SHIFT_Z  = 3'd5
    } cfg_reg_t;

    // action bits
    localparam int ACT_SHIFT_BIT  = 0;
    localparam int ACT_TENSOR_BIT = 1;

    // packed tensor slot of element (k,l): xx,yy,zz,xy,yz,xz
    localparam logic [2:0] PK [3][3] = '{'{3'd0, 3'd3, 3'd5},
                                          '{3'd3, 3'd1, 3'd4},
                                          '{3'd5, 3'd4, 3'd2}};
    // row pair (i,j) of each tensor output
    localparam logic [1:0] PI [NUM_COMP] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
    localparam logic [1:0] PJ [NUM_COMP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

endpackage

/* rtl/svt_cfg_regs.sv */
module svt_cfg_regs
    import svt_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int COEF_WIDTH = DEF_COEF_WIDTH,
    parameter int CFG_W      = 3 * DEF_COEF_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    output logic signed [COEF_WIDTH-1:0] s_mat [3][3],
    output logic signed [DATA_WIDTH-1:0] shift [3]
);

    localparam int ROW_W = 3 * COEF_WIDTH;
    localparam int CF    = COEF_WIDTH - 2;
    localparam logic [ROW_W-1:0] ONE_ROW = ROW_W'(1);

    logic [ROW_W-1:0]      row_reg [3];
    logic [DATA_WIDTH-1:0] shift_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // identity matrix, no translation
            for (int i = 0; i < 3; i++) begin
                row_reg[i]   <= ONE_ROW << (i * COEF_WIDTH + CF);
                shift_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_ZERO: row_reg[0]   <= cfg_data[ROW_W-1:0];
                REG_ROW_ONE:  row_reg[1]   <= cfg_data[ROW_W-1:0];
                REG_ROW_TWO:  row_reg[2]   <= cfg_data[ROW_W-1:0];
                REG_SHIFT_X:  shift_reg[0] <= cfg_data[DATA_WIDTH-1:0];
                REG_SHIFT_Y:  shift_reg[1] <= cfg_data[DATA_WIDTH-1:0];
                REG_SHIFT_Z:  shift_reg[2] <= cfg_data[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shift[i] = shift_reg[i];
            for (int k = 0; k < 3; k++) begin
                s_mat[i][k] = row_reg[i][k*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

endmodule

/* rtl/svt_row_stage.sv */
module svt_row_stage
    import svt_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int COEF_WIDTH = DEF_COEF_WIDTH,
    parameter int SUM_W      = DEF_DATA_WIDTH + DEF_COEF_WIDTH + 2
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         use_shift,
    input  logic signed [DATA_WIDTH-1:0] comp [NUM_COMP],
    input  logic signed [COEF_WIDTH-1:0] s_mat [3][3],
    input  logic signed [DATA_WIDTH-1:0] shift [3],
    output logic signed [SUM_W-1:0]      u_sum [3][3],
    output logic signed [SUM_W-1:0]      v_sum [3]
);

    localparam int PW = DATA_WIDTH + COEF_WIDTH;
    localparam int CF = COEF_WIDTH - 2;

    logic signed [PW-1:0] t_ext [3];
    logic signed [PW-1:0] pt_next [3][3][3];
    logic signed [PW-1:0] pv_next [3][3];
    logic signed [PW-1:0] tn_next [3];
    logic signed [PW-1:0] pt_reg [3][3][3];
    logic signed [PW-1:0] pv_reg [3][3];
    logic signed [PW-1:0] tn_reg [3];
    logic signed [SUM_W-1:0] u_reg [3][3];
    logic signed [SUM_W-1:0] v_reg [3];

    // products: tensor row terms S[j][l]*V[k][l], vector terms S[j][k]*c[j]
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t_ext[k]   = PW'(shift[k]);
            tn_next[k] = use_shift ? -(t_ext[k] <<< CF) : '0;
            for (int j = 0; j < 3; j++) begin
                pv_next[j][k] = PW'(s_mat[j][k]) * PW'(comp[j]);
                for (int l = 0; l < 3; l++) begin
                    pt_next[j][k][l] = PW'(s_mat[j][l]) * PW'(comp[PK[k][l]]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_reg <= pt_next;
            pv_reg <= pv_next;
            tn_reg <= tn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                v_reg[k] <= SUM_W'(pv_reg[0][k]) + SUM_W'(pv_reg[1][k])
                          + SUM_W'(pv_reg[2][k]) + SUM_W'(tn_reg[k]);
                for (int j = 0; j < 3; j++) begin
                    u_reg[j][k] <= SUM_W'(pt_reg[j][k][0]) + SUM_W'(pt_reg[j][k][1])
                                 + SUM_W'(pt_reg[j][k][2]);
                end
            end
        end
    end

    assign u_sum = u_reg;
    assign v_sum = v_reg;

endmodule

/* rtl/svt_pair_stage.sv */
module svt_pair_stage
    import svt_pkg::*;
#(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH,
    parameter int U_W        = DEF_DATA_WIDTH + DEF_COEF_WIDTH + 2,
    parameter int ACC_W      = DEF_DATA_WIDTH + 2 * DEF_COEF_WIDTH + 4
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [U_W-1:0]        u_sum [3][3],
    input  logic signed [COEF_WIDTH-1:0] s_mat [3][3],
    output logic signed [ACC_W-1:0]      t_acc [NUM_COMP]
);

    localparam int QW = COEF_WIDTH + U_W;

    logic signed [QW-1:0]    q_next [NUM_COMP][3];
    logic signed [QW-1:0]    q_reg  [NUM_COMP][3];
    logic signed [ACC_W-1:0] acc_reg [NUM_COMP];

    // out_ij = sum_k S[i][k] * u_j[k]
    always_comb begin
        for (int o = 0; o < NUM_COMP; o++) begin
            for (int k = 0; k < 3; k++) begin
                q_next[o][k] = QW'(s_mat[PI[o]][k]) * QW'(u_sum[PJ[o]][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
            for (int o = 0; o < NUM_COMP; o++) begin
                acc_reg[o] <= ACC_W'(q_reg[o][0]) + ACC_W'(q_reg[o][1])
                            + ACC_W'(q_reg[o][2]);
            end
        end
    end

    assign t_acc = acc_reg;

endmodule

/* rtl/svt_round_sat.sv */
module svt_round_sat
    import svt_pkg::*;
#(
    parameter int IN_W  = DEF_DATA_WIDTH + DEF_COEF_WIDTH + 2,
    parameter int SHIFT = DEF_COEF_WIDTH - 2,
    parameter int OUT_W = DEF_DATA_WIDTH
) (
    input  logic signed [IN_W-1:0]  in_val,
    output logic signed [OUT_W-1:0] out_val,
    output logic                    clip
);

    localparam int SUM_W = IN_W + 1;
    localparam int RS_W  = SUM_W - SHIFT;
    localparam logic [SUM_W-1:0] HALF =
        {{(SUM_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
    localparam logic [OUT_W-1:0] MAX_V = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] MIN_V = {1'b1, {(OUT_W - 1){1'b0}}};

    logic [SUM_W-1:0]     sum_w;
    logic [RS_W-1:0]      rs;
    logic [RS_W-OUT_W:0]  top_bits;
    logic                 in_range;

    // round half up, arithmetic shift, clamp
    always_comb begin
        sum_w    = {in_val[IN_W-1], in_val} + HALF;
        rs       = sum_w[SUM_W-1:SHIFT];
        top_bits = rs[RS_W-1:OUT_W-1];
        in_range = (&top_bits) | ~(|top_bits);
        clip     = ~in_range;
        if (in_range) begin
            out_val = rs[OUT_W-1:0];
        end else if (rs[RS_W-1]) begin
            out_val = MIN_V;
        end else begin
            out_val = MAX_V;
        end
    end

endmodule

/* rtl/symmetry_vector_tensor_transform_unit.sv */
// Symmetry transform unit: applies a configured 3x3 matrix S (signed Q2.14 by default) to
// position/force vectors and packed symmetric tensors in a fully pipelined datapath.
// One beat is accepted every clock while the output side keeps up; every result beat
// passes six registers on its way out (input register, two multiply/add stages for the
// row terms, two for the tensor pair terms, round and saturate into the output
// register). The six-stage pipeline has one multiplier per term; s_axis_tready drops
// only while a result waits in the output register and m_axis_tready is low, and then
// the whole pipeline holds. Action 0 gives the transposed
// product out_k = sum_j S[j][k]*c_j, action 1 also subtracts translation k, action 2 (and 3)
// gives out_ij = sum_kl S[i][k]*S[j][l]*V[kl]. Sums are exact, rounded half up once by
// dropping the Q.14 (tensor Q.28) product fraction bits and clamped to DATA_WIDTH bits;
// m_axis_tuser flags any clamp. The user must write registers through cfg_we/cfg_index/
// cfg_data only while the pipeline is empty; the block does not enforce this. Registers
// reset to the identity matrix and zero translation.
module symmetry_vector_tensor_transform_unit
    import svt_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [((3 * COEF_WIDTH > DATA_WIDTH) ? 3 * COEF_WIDTH : DATA_WIDTH)-1:0] cfg_data,
    // input beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // comp_zero, comp_one, comp_two, comp_three, comp_four, comp_five, zero fill
    input  logic [((NUM_COMP * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  logic [1:0]             s_axis_tuser,
    // result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_zero, out_one, out_two, out_three, out_four, out_five, zero fill
    output logic [((NUM_COMP * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // clipped
    output logic [0:0]             m_axis_tuser
);

    `include "symmetry_vector_tensor_transform_unit_assert.svh"

    localparam int CFG_W  = (3 * COEF_WIDTH > DATA_WIDTH) ? 3 * COEF_WIDTH : DATA_WIDTH;
    localparam int CF     = COEF_WIDTH - 2;
    localparam int PW     = DATA_WIDTH + COEF_WIDTH;   // one product
    localparam int U_W    = PW + 2;                    // sum of up to four products
    localparam int ACC_W  = COEF_WIDTH + U_W + 2;      // tensor accumulator
    localparam int NSTAGE = 5;                         // stages before the output register
    localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    // configuration
    logic signed [COEF_WIDTH-1:0] s_mat [3][3];
    logic signed [DATA_WIDTH-1:0] shift [3];

    // pipeline control: every stage moves when the output register can take a beat
    logic              en;
    logic [NSTAGE:1]   vld_reg;
    logic [NSTAGE:2]   tensor_reg;
    logic              out_vld_reg;
    logic              out_tensor_reg;

    // stage 1 input register
    logic [1:0]                   act_s1_reg;
    logic signed [DATA_WIDTH-1:0] comp_s1_reg [NUM_COMP];

    // datapath between stages
    logic signed [U_W-1:0]   u_sum [3][3];
    logic signed [U_W-1:0]   v_sum [3];
    logic signed [U_W-1:0]   v_s4_reg [3];
    logic signed [U_W-1:0]   v_s5_reg [3];
    logic signed [ACC_W-1:0] t_acc [NUM_COMP];

    // round and clamp results
    logic signed [DATA_WIDTH-1:0] v_out [3];
    logic [2:0]                   v_clip;
    logic signed [DATA_WIDTH-1:0] t_out [NUM_COMP];
    logic [NUM_COMP-1:0]          t_clip;

    // output register
    logic [DATA_WIDTH-1:0] out_reg [NUM_COMP];
    logic                  clip_reg;
    logic                  at_bound;

    assign en            = ~out_vld_reg | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = clip_reg;

    svt_cfg_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_mat     (s_mat),
        .shift     (shift)
    );

    // valid bits and the tensor flag travel with the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NSTAGE-1:1], s_axis_tvalid};
            out_vld_reg <= vld_reg[NSTAGE];
        end
    end

    // stage 1: capture the input beat
    always_ff @(posedge aclk) begin
        if (en) begin
            act_s1_reg <= s_axis_tuser;
            for (int i = 0; i < NUM_COMP; i++) begin
                comp_s1_reg[i] <= s_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tensor_reg     <= {tensor_reg[NSTAGE-1:2], act_s1_reg[ACT_TENSOR_BIT]};
            out_tensor_reg <= tensor_reg[NSTAGE];
        end
    end

    // stages 2 and 3: row products and their sums
    svt_row_stage #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH),
        .SUM_W      (U_W)
    ) u_row (
        .aclk      (aclk),
        .en        (en),
        .use_shift (act_s1_reg[ACT_SHIFT_BIT]),
        .comp      (comp_s1_reg),
        .s_mat     (s_mat),
        .shift     (shift),
        .u_sum     (u_sum),
        .v_sum     (v_sum)
    );

    // stages 4 and 5: tensor pair products and sums
    svt_pair_stage #(
        .COEF_WIDTH (COEF_WIDTH),
        .U_W        (U_W),
        .ACC_W      (ACC_W)
    ) u_pair (
        .aclk  (aclk),
        .en    (en),
        .u_sum (u_sum),
        .s_mat (s_mat),
        .t_acc (t_acc)
    );

    // vector sums wait alongside the tensor stages
    always_ff @(posedge aclk) begin
        if (en) begin
            v_s4_reg <= v_sum;
            v_s5_reg <= v_s4_reg;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_vec_rs
        svt_round_sat #(
            .IN_W  (U_W),
            .SHIFT (CF),
            .OUT_W (DATA_WIDTH)
        ) u_rs (
            .in_val  (v_s5_reg[k]),
            .out_val (v_out[k]),
            .clip    (v_clip[k])
        );
    end

    for (genvar o = 0; o < NUM_COMP; o++) begin : g_ten_rs
        svt_round_sat #(
            .IN_W  (ACC_W),
            .SHIFT (2 * CF),
            .OUT_W (DATA_WIDTH)
        ) u_rs (
            .in_val  (t_acc[o]),
            .out_val (t_out[o]),
            .clip    (t_clip[o])
        );
    end

    // stage 6: output register, vector beats carry zero in the upper three slots
    always_ff @(posedge aclk) begin
        if (en) begin
            if (tensor_reg[NSTAGE]) begin
                for (int o = 0; o < NUM_COMP; o++) begin
                    out_reg[o] <= t_out[o];
                end
                clip_reg <= |t_clip;
            end else begin
                for (int o = 0; o < 3; o++) begin
                    out_reg[o]     <= v_out[o];
                    out_reg[o + 3] <= '0;
                end
                clip_reg <= |v_clip;
            end
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        at_bound     = 1'b0;
        for (int o = 0; o < NUM_COMP; o++) begin
            m_axis_tdata[o*DATA_WIDTH +: DATA_WIDTH] = out_reg[o];
            at_bound = at_bound | (out_reg[o] == MAX_V) | (out_reg[o] == MIN_V);
        end
    end

    // checks
    `SVT_ASSERT_SAME(a_vec_upper_zero, aclk, aresetn, m_axis_tvalid && !out_tensor_reg, (out_reg[3] == '0) && (out_reg[4] == '0) && (out_reg[5] == '0), "vector beat with nonzero tensor slots")
    `SVT_ASSERT_SAME(a_clip_at_bound, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], at_bound, "clip flag without a clamped output")
    `SVT_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_axis_tvalid && s_axis_tready, vld_reg[1], "accepted beat missing from stage one")
    `SVT_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !s_axis_tready, $stable(vld_reg) && m_axis_tvalid, "pipeline moved during a stall")

endmodule
